// File: rtl/core/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg - shared types and constants of the source text tokenizer
// Holds the input and output word types, token kinds and the scanner states.
// ----------------------------------------------------------------------------
package stt_pkg;

	localparam int KIND_W = 4;

	typedef enum logic [KIND_W-1:0] {
		K_WORD      = 4'd0,
		K_STRING    = 4'd1,
		K_INT       = 4'd2,
		K_REAL      = 4'd3,
		K_IMAG      = 4'd4,
		K_ASSIGN    = 4'd5,
		K_ADDASSIGN = 4'd6,
		K_ARROW     = 4'd7,
		K_SYMBOL    = 4'd8,
		K_ERROR     = 4'd9,
		K_END       = 4'd10
	} kind_t;

	typedef enum logic [16:0] {
		S_IDLE    = 17'h00001,
		S_WORD    = 17'h00002,
		S_STRING  = 17'h00004,
		S_SLASH   = 17'h00008,
		S_LINECMT = 17'h00010,
		S_BLOCK   = 17'h00020,
		S_BSTAR   = 17'h00040,
		S_ZERO    = 17'h00080,
		S_INT     = 17'h00100,
		S_HEX     = 17'h00200,
		S_DOT     = 17'h00400,
		S_FRAC    = 17'h00800,
		S_EXP     = 17'h01000,
		S_EXPD    = 17'h02000,
		S_COLON   = 17'h04000,
		S_PLUS    = 17'h08000,
		S_LESS    = 17'h10000
	} scan_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} in_word_t;

	typedef struct packed {
		logic [3:0]  token_kind;
		logic [7:0]  symbol_char;
		logic [31:0] start_offset;
		logic [15:0] lexeme_length;
		logic [23:0] line_number;
		logic        last_of_run;
	} out_word_t;

	// Byte classes found by the front part.
	typedef struct packed {
		logic alpha;
		logic digit;
		logic hexd;
		logic under;
		logic quote;
		logic bslash;
		logic slash;
		logic star;
		logic dot;
		logic colon;
		logic plus;
		logic minus;
		logic less;
		logic equal;
		logic nl;
		logic lx;
		logic le;
		logic li;
		logic sym1;
		logic zero;
	} cls_t;

	typedef struct packed {
		logic [7:0] c;
		logic       eot;
		cls_t       cl;
	} item_t;

	function automatic cls_t classify(input logic [7:0] c);
		cls_t r;
		logic [7:0] l;
		l = c | 8'h20;
		r.alpha  = (l >= "a") && (l <= "z");
		r.digit  = (c >= "0") && (c <= "9");
		r.hexd   = r.digit || ((l >= "a") && (l <= "f"));
		r.under  = c == "_";
		r.quote  = c == 8'h22;
		r.bslash = c == 8'h5c;
		r.slash  = c == "/";
		r.star   = c == "*";
		r.dot    = c == ".";
		r.colon  = c == ":";
		r.plus   = c == "+";
		r.minus  = c == "-";
		r.less   = c == "<";
		r.equal  = c == "=";
		r.nl     = c == 8'h0a;
		r.lx     = l == "x";
		r.le     = l == "e";
		r.li     = c == "i";
		r.zero   = c == "0";
		r.sym1   = (c == ";") || (c == ",") || (c == "=") || (c == "-") || (c == "*")
			|| (c == "(") || (c == ")") || (c == "[") || (c == "]") || (c == "{")
			|| (c == "}");
		return r;
	endfunction

endpackage

// File: rtl/core/source_text_tokenizer_core.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer_core - byte-serial lexer top level
// Front classifier, two-entry queue and lexer automaton with result queue.
// ----------------------------------------------------------------------------
// Usage:
//  The input channel takes one word per cycle: a source byte, or an end
//  marker. The output channel gives tokens with kind, symbol byte, start
//  offset, length (saturating) and line; last_of_run marks the final token
//  caused by one input word. One input word gives zero, one or two tokens.
//  An input word is classified as it is registered into the input queue;
//  the automaton steps on the queue head and registers its tokens into the
//  result queue, which drives the output. Throughput: one input word per
//  cycle while the result queue has room, set by the single automaton step;
//  output is one token per cycle, so runs of two-token words slow intake.
//  A four-entry result queue holds tokens while the receiver stalls; the
//  automaton steps only when two entries are free, and the two-entry input
//  queue then fills and raises stall.
//  Reset clears the scanner to idle, offset 0, line 1, both queues empty.
// ----------------------------------------------------------------------------
module source_text_tokenizer_core #(
	parameter int LENGTH_WIDTH = 16,
	parameter int LINE_WIDTH   = 24,
	parameter int OFFSET_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  stt_pkg::in_word_t  in_word,
	output logic               out_valid,
	input  logic               out_stall,
	output stt_pkg::out_word_t out_word
);
	import stt_pkg::*;

	logic  q_valid, q_pop;
	item_t q_item;

	stt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_item   (q_item)
	);

	stt_back #(
		.LENGTH_WIDTH (LENGTH_WIDTH),
		.LINE_WIDTH   (LINE_WIDTH),
		.OFFSET_WIDTH (OFFSET_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_item    (q_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);
endmodule

// File: rtl/core/stt_front.sv
// ----------------------------------------------------------------------------
// stt_front - input stage and classifier
// Registers accepted bytes with their character classes into a two-entry queue.
// ----------------------------------------------------------------------------
module stt_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  stt_pkg::in_word_t in_word,
	output logic             q_valid,
	input  logic             q_pop,
	output stt_pkg::item_t   q_item
);
	import stt_pkg::*;

	item_t      buf_q [2];
	logic       rd_q, wr_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_stall = cnt_q == 2'd2;
	assign push     = in_valid && !in_stall;
	assign q_valid  = cnt_q != 2'd0;
	assign q_item   = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q].c   <= in_word.text_byte;
			buf_q[wr_q].eot <= in_word.end_of_text;
			buf_q[wr_q].cl  <= classify(in_word.text_byte);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (q_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue count out of range");
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> (rd_q == wr_q))
		else $error("empty queue pointers differ");
endmodule

// File: rtl/core/stt_back.sv
// ----------------------------------------------------------------------------
// stt_back - lexer automaton and result queue
// Steps the scanner once per item and posts up to two tokens to a small queue.
// ----------------------------------------------------------------------------
module stt_back #(
	parameter int LENGTH_WIDTH = 16,
	parameter int LINE_WIDTH   = 24,
	parameter int OFFSET_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_pop,
	input  stt_pkg::item_t    q_item,
	output logic              out_valid,
	input  logic              out_stall,
	output stt_pkg::out_word_t out_word
);
	import stt_pkg::*;

	localparam logic [LENGTH_WIDTH-1:0] LenMax = '1;
	localparam logic [LINE_WIDTH-1:0]   LineMax = '1;

	scan_t                   st_q;
	logic [OFFSET_WIDTH-1:0] start_q, pos_q;
	logic [LENGTH_WIDTH-1:0] len_q;
	logic [LINE_WIDTH-1:0]   line_q;
	logic                    esc_q;

	out_word_t  obuf_q [4];
	logic [1:0] ord_q, owr_q;
	logic [2:0] ocnt_q;

	// next-state values of one step
	scan_t                   st_n;
	logic [OFFSET_WIDTH-1:0] start_n;
	logic [LENGTH_WIDTH-1:0] len_n;
	logic [LINE_WIDTH-1:0]   line_n;
	logic                    esc_n;
	logic                    e0, e1;
	out_word_t               r0, r1;
	logic                    rescan;
	kind_t                   fk;
	logic [7:0]              fs;
	logic                    fe;
	logic [7:0]              c;
	cls_t                    k;
	logic [OFFSET_WIDTH-1:0] pos_inc;

	assign c       = q_item.c;
	assign k       = q_item.cl;
	assign pos_inc = pos_q + {{(OFFSET_WIDTH-1){1'b0}}, 1'b1};

	function automatic out_word_t mk(input kind_t kd, input logic [7:0] s,
		input logic [OFFSET_WIDTH-1:0] so, input logic [LENGTH_WIDTH-1:0] ln,
		input logic [LINE_WIDTH-1:0] li);
		out_word_t w;
		w = '0;
		w.token_kind    = kd;
		w.symbol_char   = s;
		w.start_offset  = 32'(so);
		w.lexeme_length = 16'(ln);
		w.line_number   = 24'(li);
		return w;
	endfunction

	function automatic logic [LENGTH_WIDTH-1:0] inc_len(input logic [LENGTH_WIDTH-1:0] v);
		return (v == LenMax) ? v : v + {{(LENGTH_WIDTH-1){1'b0}}, 1'b1};
	endfunction

	// pending token ended by a non-matching byte
	always_comb begin
		fe = 1'b1;
		fs = 8'd0;
		fk = K_WORD;
		case (st_q)
			S_WORD: fk = K_WORD;
			S_STRING, S_BLOCK, S_BSTAR: fk = K_ERROR;
			S_SLASH: begin fk = K_SYMBOL; fs = "/"; end
			S_ZERO, S_INT, S_HEX: fk = K_INT;
			S_DOT: begin fk = K_SYMBOL; fs = "."; end
			S_FRAC, S_EXP, S_EXPD: fk = K_REAL;
			S_COLON: begin fk = K_SYMBOL; fs = ":"; end
			S_PLUS: begin fk = K_SYMBOL; fs = "+"; end
			S_LESS: begin fk = K_SYMBOL; fs = "<"; end
			default: fe = 1'b0;
		endcase
	end

	always_comb begin
		logic [LINE_WIDTH-1:0] ln_inc;
		logic                  nl_line;
		st_n    = st_q;
		start_n = start_q;
		len_n   = len_q;
		line_n  = line_q;
		esc_n   = esc_q;
		e0      = 1'b0;
		e1      = 1'b0;
		r0      = '0;
		r1      = '0;
		rescan  = 1'b0;
		nl_line = 1'b0;
		if (q_item.eot) begin
			if (fe) begin
				e0 = 1'b1;
				r0 = mk(fk, fs, start_q, len_q, line_q);
				e1 = 1'b1;
				r1 = mk(K_END, 8'd0, pos_q, '0, line_q);
			end else begin
				e0 = 1'b1;
				r0 = mk(K_END, 8'd0, pos_q, '0, line_q);
			end
			st_n  = S_IDLE;
			esc_n = 1'b0;
		end else begin
			case (st_q)
				S_WORD: begin
					if (k.alpha || k.digit || k.under) len_n = inc_len(len_q);
					else rescan = 1'b1;
				end
				S_STRING: begin
					len_n = inc_len(len_q);
					nl_line = k.nl;
					if (esc_q) esc_n = 1'b0;
					else if (k.bslash) esc_n = 1'b1;
					else if (k.quote) begin
						e0 = 1'b1;
						st_n = S_IDLE;
					end
				end
				S_SLASH: begin
					if (k.slash) st_n = S_LINECMT;
					else if (k.star) begin
						len_n = inc_len(len_q);
						st_n = S_BLOCK;
					end else rescan = 1'b1;
				end
				S_LINECMT: begin
					if (k.nl) begin
						st_n = S_IDLE;
						rescan = 1'b1;
					end
				end
				S_BLOCK, S_BSTAR: begin
					len_n = inc_len(len_q);
					nl_line = k.nl;
					if (st_q == S_BSTAR && k.slash) st_n = S_IDLE;
					else st_n = k.star ? S_BSTAR : S_BLOCK;
				end
				S_ZERO, S_INT: begin
					if (st_q == S_ZERO && k.lx) begin
						len_n = inc_len(len_q);
						st_n = S_HEX;
					end else if (k.digit) begin
						len_n = inc_len(len_q);
						st_n = S_INT;
					end else if (k.dot) begin
						len_n = inc_len(len_q);
						st_n = S_FRAC;
					end else if (k.le) begin
						len_n = inc_len(len_q);
						st_n = S_EXP;
					end else if (k.li) begin
						len_n = inc_len(len_q);
						e0 = 1'b1;
						st_n = S_IDLE;
					end else rescan = 1'b1;
				end
				S_HEX: begin
					if (k.hexd) len_n = inc_len(len_q);
					else rescan = 1'b1;
				end
				S_DOT: begin
					if (k.digit) begin
						len_n = inc_len(len_q);
						st_n = S_FRAC;
					end else rescan = 1'b1;
				end
				S_FRAC: begin
					if (k.digit) len_n = inc_len(len_q);
					else if (k.le) begin
						len_n = inc_len(len_q);
						st_n = S_EXP;
					end else rescan = 1'b1;
				end
				S_EXP, S_EXPD: begin
					if (st_q == S_EXP && (k.plus || k.minus)) begin
						len_n = inc_len(len_q);
						st_n = S_EXPD;
					end else if (k.digit) begin
						len_n = inc_len(len_q);
						st_n = S_EXPD;
					end else if (k.li) begin
						len_n = inc_len(len_q);
						e0 = 1'b1;
						st_n = S_IDLE;
					end else rescan = 1'b1;
				end
				S_COLON, S_PLUS, S_LESS: begin
					if ((st_q == S_COLON && k.equal) || (st_q == S_PLUS && k.equal)
						|| (st_q == S_LESS && k.minus)) begin
						len_n = inc_len(len_q);
						e0 = 1'b1;
						st_n = S_IDLE;
					end else rescan = 1'b1;
				end
				default: rescan = 1'b1;
			endcase
			// token finished inside the state: kind follows the state
			if (e0) begin
				case (st_q)
					S_STRING: r0 = mk(K_STRING, 8'd0, start_q, len_n, line_q);
					S_COLON: r0 = mk(K_ASSIGN, 8'd0, start_q, len_n, line_q);
					S_PLUS: r0 = mk(K_ADDASSIGN, 8'd0, start_q, len_n, line_q);
					S_LESS: r0 = mk(K_ARROW, 8'd0, start_q, len_n, line_q);
					default: r0 = mk(K_IMAG, 8'd0, start_q, len_n, line_q);
				endcase
			end
			// a string token carries the line after its own newline bump
			ln_inc = (line_q == LineMax) ? line_q
				: line_q + {{(LINE_WIDTH-1){1'b0}}, 1'b1};
			if (nl_line) begin
				line_n = ln_inc;
				r0.line_number = 24'(ln_inc);
			end
			if (rescan) begin
				// flush of the pending token (not after a line comment)
				if (st_q != S_LINECMT && fe) begin
					e0 = 1'b1;
					r0 = mk(fk, fs, start_q, len_q, line_q);
				end
				esc_n = 1'b0;
				st_n = S_IDLE;
				start_n = pos_q;
				len_n = {{(LENGTH_WIDTH-1){1'b0}}, 1'b1};
				if (k.alpha || k.under) st_n = S_WORD;
				else if (k.quote) st_n = S_STRING;
				else if (k.slash) st_n = S_SLASH;
				else if (k.sym1) begin
					if (e0) begin
						e1 = 1'b1;
						r1 = mk(K_SYMBOL, c, pos_q, len_n, line_q);
					end else begin
						e0 = 1'b1;
						r0 = mk(K_SYMBOL, c, pos_q, len_n, line_q);
					end
				end else if (k.zero) st_n = S_ZERO;
				else if (k.digit) st_n = S_INT;
				else if (k.dot) st_n = S_DOT;
				else if (k.colon) st_n = S_COLON;
				else if (k.plus) st_n = S_PLUS;
				else if (k.less) st_n = S_LESS;
				else if (k.nl) line_n = ln_inc;
			end
		end
		if (e1) r1.last_of_run = 1'b1;
		else r0.last_of_run = 1'b1;
	end

	// room for two results keeps the step atomic
	assign q_pop     = q_valid && (ocnt_q <= 3'd2);
	assign out_valid = ocnt_q != 3'd0;
	assign out_word  = obuf_q[ord_q];

	logic opop;
	assign opop = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (q_pop && e0) obuf_q[owr_q] <= r0;
		if (q_pop && e1) obuf_q[owr_q + 2'd1] <= r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			start_q <= '0;
			len_q   <= '0;
			pos_q   <= '0;
			line_q  <= {{(LINE_WIDTH-1){1'b0}}, 1'b1};
			esc_q   <= 1'b0;
			ord_q   <= '0;
			owr_q   <= '0;
			ocnt_q  <= '0;
		end else begin
			if (q_pop) begin
				st_q    <= st_n;
				start_q <= start_n;
				len_q   <= len_n;
				line_q  <= line_n;
				esc_q   <= esc_n;
				if (!q_item.eot) pos_q <= pos_inc;
			end
			owr_q  <= owr_q + (q_pop ? {1'b0, e0} + {1'b0, e1} : 2'd0);
			ord_q  <= ord_q + {1'b0, opop};
			ocnt_q <= ocnt_q + (q_pop ? {2'b0, e0} + {2'b0, e1} : 3'd0) - {2'b0, opop};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) ocnt_q <= 3'd4)
		else $error("result queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) $onehot(st_q))
		else $error("scanner state not one-hot");
	assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_item.eot) |=> (st_q == S_IDLE))
		else $error("scanner not idle after end of text");
	assert property (@(posedge clk) disable iff (!arst_n)
		(line_q != '0))
		else $error("line count reached zero");
endmodule

// File: test/tb_source_text_tokenizer_core.sv
// ----------------------------------------------------------------------------
// tb_source_text_tokenizer_core - self-checking bench of the byte-serial lexer
// Drives source bytes and end markers with random gaps, predicts every token
// with an independent scanner model and checks tokens in order.
// ----------------------------------------------------------------------------
module tb_source_text_tokenizer_core;
	import stt_pkg::*;

	// scanner states of the predictor
	typedef enum int {
		P_IDLE, P_WORD, P_STRING, P_SLASH, P_LINECMT, P_BLOCK, P_BSTAR, P_ZERO,
		P_INT, P_HEX, P_DOT, P_FRAC, P_EXP, P_EXPD, P_COLON, P_PLUS, P_LESS
	} pstate_t;

	localparam logic [15:0] LEN_SAT  = 16'hFFFF;
	localparam logic [23:0] LINE_SAT = 24'hFFFFFF;
	localparam int WATCHDOG = 4000;

	// token predictor and store of expected tokens
	class token_scoreboard;
		pstate_t     st;
		logic [31:0] tok_start;
		logic [15:0] tok_len;
		logic [31:0] pos;
		logic [23:0] line;
		bit          esc;
		out_word_t   pending[$];
		out_word_t   step_toks[$];
		int          errors;

		function void clear();
			st = P_IDLE; tok_start = 0; tok_len = 0; pos = 0; line = 1; esc = 0;
			pending.delete(); errors = 0;
		endfunction

		function void emit(kind_t k, logic [7:0] s, logic [31:0] o, logic [15:0] n);
			out_word_t w;
			if (step_toks.size() >= 2) return;
			w.token_kind = k; w.symbol_char = s; w.start_offset = o;
			w.lexeme_length = n; w.line_number = line; w.last_of_run = 0;
			step_toks.push_back(w);
		endfunction

		function void grow(); if (tok_len != LEN_SAT) tok_len++; endfunction
		function void nl(); if (line != LINE_SAT) line++; endfunction
		function void close_tok(kind_t k, logic [7:0] s);
			emit(k, s, tok_start, tok_len); st = P_IDLE;
		endfunction

		function void flush();
			case (st)
				P_WORD: close_tok(K_WORD, 0);
				P_STRING, P_BLOCK, P_BSTAR: close_tok(K_ERROR, 0);
				P_SLASH: close_tok(K_SYMBOL, "/");
				P_ZERO, P_INT, P_HEX: close_tok(K_INT, 0);
				P_DOT: close_tok(K_SYMBOL, ".");
				P_FRAC, P_EXP, P_EXPD: close_tok(K_REAL, 0);
				P_COLON: close_tok(K_SYMBOL, ":");
				P_PLUS: close_tok(K_SYMBOL, "+");
				P_LESS: close_tok(K_SYMBOL, "<");
				default: ;
			endcase
			st = P_IDLE; esc = 0;
		endfunction

		// feed a byte to the open token; 1 when it must be rescanned from idle
		function bit feed(logic [7:0] c);
			bit al, dg, hx;
			al = ((c | 8'h20) >= "a") && ((c | 8'h20) <= "z");
			dg = (c >= "0") && (c <= "9");
			hx = dg || (((c | 8'h20) >= "a") && ((c | 8'h20) <= "f"));
			case (st)
				P_WORD: if (al || dg || c == "_") begin grow(); return 0; end
				P_STRING: begin
					grow();
					if (c == 8'h0a) nl();
					if (esc) esc = 0;
					else if (c == 8'h5c) esc = 1;
					else if (c == 8'h22) close_tok(K_STRING, 0);
					return 0;
				end
				P_SLASH: begin
					if (c == "/") begin st = P_LINECMT; return 0; end
					if (c == "*") begin grow(); st = P_BLOCK; return 0; end
				end
				P_LINECMT: begin
					if (c == 8'h0a) begin st = P_IDLE; return 1; end
					return 0;
				end
				P_BLOCK, P_BSTAR: begin
					grow();
					if (c == 8'h0a) nl();
					if (st == P_BSTAR && c == "/") begin st = P_IDLE; return 0; end
					st = (c == "*") ? P_BSTAR : P_BLOCK;
					return 0;
				end
				P_ZERO, P_INT: begin
					if (st == P_ZERO && (c == "x" || c == "X")) begin
						grow(); st = P_HEX; return 0;
					end
					if (dg) begin grow(); st = P_INT; return 0; end
					if (c == ".") begin grow(); st = P_FRAC; return 0; end
					if (c == "e" || c == "E") begin grow(); st = P_EXP; return 0; end
					if (c == "i") begin grow(); close_tok(K_IMAG, 0); return 0; end
				end
				P_HEX: if (hx) begin grow(); return 0; end
				P_DOT: if (dg) begin grow(); st = P_FRAC; return 0; end
				P_FRAC: begin
					if (dg) begin grow(); return 0; end
					if (c == "e" || c == "E") begin grow(); st = P_EXP; return 0; end
				end
				P_EXP, P_EXPD: begin
					if (st == P_EXP && (c == "+" || c == "-")) begin
						grow(); st = P_EXPD; return 0;
					end
					if (dg) begin grow(); st = P_EXPD; return 0; end
					if (c == "i") begin grow(); close_tok(K_IMAG, 0); return 0; end
				end
				P_COLON: if (c == "=") begin grow(); close_tok(K_ASSIGN, 0); return 0; end
				P_PLUS: if (c == "=") begin grow(); close_tok(K_ADDASSIGN, 0); return 0; end
				P_LESS: if (c == "-") begin grow(); close_tok(K_ARROW, 0); return 0; end
				default: begin st = P_IDLE; return 1; end
			endcase
			flush();
			return 1;
		endfunction

		function void open_tok(logic [7:0] c);
			tok_start = pos; tok_len = 1; esc = 0;
			if ((((c | 8'h20) >= "a") && ((c | 8'h20) <= "z")) || c == "_") st = P_WORD;
			else if (c == 8'h22) st = P_STRING;
			else if (c == "/") st = P_SLASH;
			else if (c == ";" || c == "," || c == "=" || c == "-" || c == "*" ||
				c == "(" || c == ")" || c == "[" || c == "]" || c == "{" || c == "}")
				emit(K_SYMBOL, c, tok_start, tok_len);
			else if (c == "0") st = P_ZERO;
			else if (c >= "1" && c <= "9") st = P_INT;
			else if (c == ".") st = P_DOT;
			else if (c == ":") st = P_COLON;
			else if (c == "+") st = P_PLUS;
			else if (c == "<") st = P_LESS;
			else if (c == 8'h0a) nl();
		endfunction

		// note an accepted input word and queue the tokens it causes
		function void note_input(in_word_t w);
			step_toks.delete();
			if (w.end_of_text) begin
				flush();
				emit(K_END, 0, pos, 0);
			end else begin
				if (feed(w.text_byte)) open_tok(w.text_byte);
				pos++;
			end
			if (step_toks.size() > 0) step_toks[step_toks.size()-1].last_of_run = 1;
			foreach (step_toks[i]) pending.push_back(step_toks[i]);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch %s: got %0h expected %0h", what, got, want);
			errors++;
		endtask

		task check_token(out_word_t g);
			out_word_t e;
			if (pending.size() == 0) begin
				report("unexpected token kind", g.token_kind, 0);
				return;
			end
			e = pending.pop_front();
			if (g.token_kind != e.token_kind) report("kind", g.token_kind, e.token_kind);
			if (g.symbol_char != e.symbol_char) report("symbol", g.symbol_char, e.symbol_char);
			if (g.start_offset != e.start_offset)
				report("offset", g.start_offset, e.start_offset);
			if (g.lexeme_length != e.lexeme_length)
				report("length", g.lexeme_length, e.lexeme_length);
			if (g.line_number != e.line_number) report("line", g.line_number, e.line_number);
			if (g.last_of_run != e.last_of_run) report("last", g.last_of_run, e.last_of_run);
		endtask
	endclass

	logic      clk = 0;
	logic      arst_n = 0;
	logic      in_valid = 0;
	logic      in_stall;
	in_word_t  in_word = '0;
	logic      out_valid;
	logic      out_stall = 0;
	out_word_t out_word;

	token_scoreboard sb = new();
	bit calm = 0;          // long stretch without idling
	bit paused = 0;        // drain pause done
	int n_sent = 0;        // input words accepted so far
	int quiet = 0;         // cycles without any handshake
	bit timed_out = 0;

	always #5 clk = ~clk;

	source_text_tokenizer_core DUT (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_word(in_word), .out_valid(out_valid), .out_stall(out_stall),
		.out_word(out_word)
	);

	// sample on the rising edge, predict on input accepts, check tokens
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) sb.note_input(in_word);
			if (out_valid && !out_stall) sb.check_token(out_word);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
			else quiet++;
			if (quiet >= WATCHDOG) timed_out = 1;
		end
	end

	// receiver stalls about a quarter of the time
	always @(negedge clk)
		out_stall <= calm ? 1'b0 : ($urandom_range(99) < 26);

	// one source word; held until accepted
	task automatic send_word(logic [7:0] c, logic eot);
		if (!calm)
			while ($urandom_range(99) < 26) begin
				in_valid <= 0;
				@(negedge clk);
			end
		in_valid <= 1;
		in_word.text_byte <= c;
		in_word.end_of_text <= eot;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(string s);
		foreach (s[i]) send_word(s[i], 0);
	endtask

	// byte from a lexer-friendly alphabet, sometimes any byte
	function automatic logic [7:0] pick_byte();
		string alpha = "abxXeEi_0190.;:=+<-*/\"\\ \n(){}[],zF";
		if ($urandom_range(9) == 0) return $urandom_range(255);
		return alpha[$urandom_range(alpha.len()-1)];
	endfunction

	task automatic send_fragment();
		int n;
		case ($urandom_range(7))
			0: send_text("word_1 ");
			1: send_text("\"a\\\"b\\\\\" ");
			2: send_text("0x1Fg 0x ");
			3: send_text("3.14e-5i 2ei 1.5i ");
			4: send_text("/* x\n** */a//c\nb");
			5: send_text("x:=1;y+=2<-3 :+<./");
			6: send_text("42i .5 . ");
			default: begin
				n = $urandom_range(1, 12);
				repeat (n) send_word(pick_byte(), 0);
			end
		endcase
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		while (sb.pending.size() != 0 && !timed_out) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	initial begin
		sb.clear();
		repeat (3) @(negedge clk);
		arst_n = 1;
		// directed: extremes, every token kind but real, unterminated cases, end marker
		send_text("ab_9 \"q\\\"\" 0x 07 1.2e+3i");
		send_word(8'h00, 0);
		send_word(8'hFF, 1);
		send_text("/* open");
		send_word(8'h00, 1);
		send_text("\"open\n");
		send_word(8'h80, 1);
		send_text(":= += <- .x");
		send_word(8'h7F, 1);
		// random, with one calm stretch and one drain pause
		while (n_sent < 550 && !timed_out) begin
			calm = (n_sent > 150 && n_sent < 260);
			if (n_sent > 350 && !paused) begin
				wait_drained();
				paused = 1;
			end
			if ($urandom_range(19) == 0) send_word($urandom_range(255), 1);
			else send_fragment();
		end
		calm = 0;
		send_word(8'h00, 1);
		wait_drained();
		if (timed_out) begin
			$display("status: fail");
		end else if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// watchdog exit while stimulus is blocked on a handshake
	always @(posedge clk)
		if (quiet >= WATCHDOG + 20) begin
			$display("status: fail");
			$finish;
		end
endmodule

// File: filelist.f
rtl/core/stt_pkg.sv
rtl/core/stt_front.sv
rtl/core/stt_back.sv
rtl/core/source_text_tokenizer_core.sv
test/tb_source_text_tokenizer_core.sv
